@@ rtl/core/ppsel_pkg.sv @@
// ----------------------------------------------------------------------------
// ppsel_pkg
// Shared types and constants for the point pick selector: command and status
// codes, controller states and the flag group of the evaluation pipeline.
// ----------------------------------------------------------------------------
package ppsel_pkg;

  // coordinate and distance widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SQ_W    = 2 * COORD_W;
  localparam int unsigned DIST_W  = SQ_W + 1;
  localparam int unsigned RAD_W   = 16;

  // output field widths
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PICK_W    = 6;
  localparam int unsigned MATCH_W   = 7;
  localparam int unsigned STORED_W  = 7;
  localparam int unsigned SEL_LEN_W = 9;

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(160);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_PICK   = 2'd1,
    CMD_RECT   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE       = 2'd0,
    ST_MISS       = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_LIST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_DRAIN  = 2'd2,
    S_RESULT = 2'd3
  } state_t;

  // flags leaving the evaluation pipeline
  typedef struct packed {
    logic busy;   // a beat sits in an earlier stage
    logic vld;    // last stage holds a beat this cycle
    logic inbox;  // point of that beat lies in the rectangle
  } ev_flags_t;

endpackage

@@ rtl/core/point_pick_selector_top.sv @@
// ----------------------------------------------------------------------------
// point_pick_selector_top
// Point table with nearest-point pick and rectangle selection into an
// append-only selection list. Points and the list live in synchronous RAMs.
// ----------------------------------------------------------------------------
// Sequence: insert and clear finish when the beat is taken and go straight
//   to S_RESULT; pick and rectangle scan the stored points in S_SCAN, wait
//   in S_DRAIN for the pipeline to empty, then go to S_RESULT (directly
//   when the table is empty). Throughput: one item at a time; the point
//   RAM read port scans one point per cycle.
// Reset: counters clear, radius returns to 160; RAM contents are undefined.
// ----------------------------------------------------------------------------
module point_pick_selector_top #(
  parameter int unsigned MAX_POINTS   = 64,
  parameter int unsigned SELECT_DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // configuration
  input  logic                                    cfg_we,
  input  logic [ppsel_pkg::RAD_W-1:0]             cfg_wdata,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              in_command,
  input  logic signed [ppsel_pkg::COORD_W-1:0]    in_x0,
  input  logic signed [ppsel_pkg::COORD_W-1:0]    in_y0,
  input  logic signed [ppsel_pkg::COORD_W-1:0]    in_x1,
  input  logic signed [ppsel_pkg::COORD_W-1:0]    in_y1,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [ppsel_pkg::STATUS_W-1:0]          out_status,
  output logic [ppsel_pkg::PICK_W-1:0]            out_picked_index,
  output logic [ppsel_pkg::MATCH_W-1:0]           out_matched_count,
  output logic [ppsel_pkg::STORED_W-1:0]          out_stored_points,
  output logic [ppsel_pkg::SEL_LEN_W-1:0]         out_selection_length
);
  import ppsel_pkg::*;

  localparam int unsigned PI_W = $clog2(MAX_POINTS);
  localparam int unsigned PT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned SI_W = $clog2(SELECT_DEPTH);
  localparam int unsigned ST_W = $clog2(SELECT_DEPTH + 1);
  localparam int unsigned MC_W = $clog2(MAX_POINTS + 1);

  state_t state_r, state_nxt;

  logic [RAD_W-1:0]          radius_r;
  logic [2*RAD_W-1:0]        rad2_r, rad2_nxt;
  cmd_t                      cmd_r, cmd_nxt;
  logic signed [COORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [COORD_W-1:0] xl_r, xl_nxt, xh_r, xh_nxt;
  logic signed [COORD_W-1:0] yl_r, yl_nxt, yh_r, yh_nxt;
  logic [PT_W-1:0]           pt_total_r, pt_total_nxt;
  logic [ST_W-1:0]           sel_total_r, sel_total_nxt;
  logic [PI_W-1:0]           iss_r, iss_nxt;
  logic                      rd_vld_r;
  logic [PI_W-1:0]           rd_idx_r;
  logic [DIST_W-1:0]         best_d_r, best_d_nxt;
  logic [PI_W-1:0]           best_i_r, best_i_nxt;
  logic [PI_W-1:0]           pick_r, pick_nxt;
  logic [MC_W-1:0]           matched_r, matched_nxt;
  status_t                   status_r, status_nxt;

  logic                      out_valid_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic [PICK_W-1:0]         out_pick_r;
  logic [MATCH_W-1:0]        out_matched_r;
  logic [STORED_W-1:0]       out_stored_r;
  logic [SEL_LEN_W-1:0]      out_sel_len_r;

  // RAM ports and control
  logic                      pt_we;
  logic                      pt_re;
  logic [2*COORD_W-1:0]      pt_rdata;
  logic                      sel_we;
  logic [PI_W-1:0]           sel_wdata;
  logic                      out_load;
  logic                      drained;
  logic                      pt_room, sel_room;
  cmd_t                      in_cmd;

  ev_flags_t                 ev;
  logic [PI_W-1:0]           ev_idx;
  logic [DIST_W-1:0]         ev_dist;

  assign in_cmd   = cmd_t'(in_command);
  assign pt_room  = pt_total_r < PT_W'(MAX_POINTS);
  assign sel_room = sel_total_r < ST_W'(SELECT_DEPTH);
  assign drained  = !rd_vld_r && !ev.busy && !ev.vld;

  // point table: x in the upper half, y in the lower
  ppsel_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_POINTS)
  ) u_pt_ram (
    .clk     (clk),
    .wr_en   (pt_we),
    .wr_addr (pt_total_r[PI_W-1:0]),
    .wr_data ({in_x0, in_y0}),
    .rd_en   (pt_re),
    .rd_addr (iss_r),
    .rd_data (pt_rdata)
  );

  // selection list, append only
  ppsel_ram #(
    .WIDTH (PI_W),
    .DEPTH (SELECT_DEPTH)
  ) u_sel_ram (
    .clk     (clk),
    .wr_en   (sel_we),
    .wr_addr (sel_total_r[SI_W-1:0]),
    .wr_data (sel_wdata),
    .rd_en   (1'b0),
    .rd_addr ('0),
    .rd_data ()
  );

  ppsel_eval #(
    .IDX_W (PI_W)
  ) u_eval (
    .clk      (clk),
    .rst_n    (rst_n),
    .pt_vld   (rd_vld_r),
    .pt_idx   (rd_idx_r),
    .pt_x     (pt_rdata[2*COORD_W-1:COORD_W]),
    .pt_y     (pt_rdata[COORD_W-1:0]),
    .cur_x    (cx_r),
    .cur_y    (cy_r),
    .box_xl   (xl_r),
    .box_xh   (xh_r),
    .box_yl   (yl_r),
    .box_yh   (yh_r),
    .ev_flags (ev),
    .ev_idx   (ev_idx),
    .ev_dist  (ev_dist)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if ((in_cmd == CMD_PICK || in_cmd == CMD_RECT) && pt_total_r != '0) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_SCAN: begin
        if (iss_r == PI_W'(pt_total_r - PT_W'(1))) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drained) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    pt_re    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      S_IDLE:   in_ready = 1'b1;
      S_SCAN:   pt_re    = 1'b1;
      S_DRAIN:  ;
      S_RESULT: out_load = !out_valid_r || out_ready;
      default:  ;
    endcase
  end

  // datapath: accept, scan updates and pick finish
  always_comb begin
    rad2_nxt      = rad2_r;
    cmd_nxt       = cmd_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    xl_nxt        = xl_r;
    xh_nxt        = xh_r;
    yl_nxt        = yl_r;
    yh_nxt        = yh_r;
    pt_total_nxt  = pt_total_r;
    sel_total_nxt = sel_total_r;
    iss_nxt       = iss_r;
    best_d_nxt    = best_d_r;
    best_i_nxt    = best_i_r;
    pick_nxt      = pick_r;
    matched_nxt   = matched_r;
    status_nxt    = status_r;
    pt_we         = 1'b0;
    sel_we        = 1'b0;
    sel_wdata     = ev_idx;

    // take a new beat and run insert and clear, which need no scan
    if (in_valid && in_ready) begin
      cmd_nxt     = in_cmd;
      cx_nxt      = in_x0;
      cy_nxt      = in_y0;
      xl_nxt      = (in_x0 < in_x1) ? in_x0 : in_x1;
      xh_nxt      = (in_x0 < in_x1) ? in_x1 : in_x0;
      yl_nxt      = (in_y0 < in_y1) ? in_y0 : in_y1;
      yh_nxt      = (in_y0 < in_y1) ? in_y1 : in_y0;
      rad2_nxt    = radius_r * radius_r;
      iss_nxt     = '0;
      best_d_nxt  = '0;
      best_i_nxt  = '0;
      pick_nxt    = '0;
      matched_nxt = '0;
      status_nxt  = ST_DONE;
      case (in_cmd)
        CMD_INSERT: begin
          if (pt_room) begin
            pt_we        = 1'b1;
            pt_total_nxt = pt_total_r + PT_W'(1);
          end else begin
            status_nxt = ST_TABLE_FULL;
          end
        end
        CMD_PICK: begin
          if (pt_total_r == '0) begin
            status_nxt = ST_MISS;
          end
        end
        CMD_RECT:  ;
        CMD_CLEAR: sel_total_nxt = '0;
        default:   ;
      endcase
    end

    // advance the read address
    if (pt_re) begin
      iss_nxt = iss_r + PI_W'(1);
    end

    // fold each evaluated point
    if (ev.vld) begin
      case (cmd_r)
        CMD_PICK: begin
          if (ev_idx == '0 || ev_dist < best_d_r) begin
            best_d_nxt = ev_dist;
            best_i_nxt = ev_idx;
          end
        end
        CMD_RECT: begin
          if (ev.inbox) begin
            if (sel_room) begin
              sel_we        = 1'b1;
              sel_total_nxt = sel_total_r + ST_W'(1);
              matched_nxt   = matched_r + MC_W'(1);
            end else begin
              status_nxt = ST_LIST_FULL;
            end
          end
        end
        default: ;
      endcase
    end

    // finish a pick: radius test and append
    if (state_r == S_DRAIN && drained && cmd_r == CMD_PICK) begin
      if (best_d_r < DIST_W'(rad2_r)) begin
        pick_nxt = best_i_r;
        if (sel_room) begin
          sel_we        = 1'b1;
          sel_wdata     = best_i_r;
          sel_total_nxt = sel_total_r + ST_W'(1);
          matched_nxt   = MC_W'(1);
        end else begin
          status_nxt = ST_LIST_FULL;
        end
      end else begin
        status_nxt = ST_MISS;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radius_r    <= RADIUS_RESET;
      pt_total_r  <= '0;
      sel_total_r <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pt_total_r  <= pt_total_nxt;
      sel_total_r <= sel_total_nxt;
      rd_vld_r    <= pt_re;
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rad2_r    <= rad2_nxt;
    cmd_r     <= cmd_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    xl_r      <= xl_nxt;
    xh_r      <= xh_nxt;
    yl_r      <= yl_nxt;
    yh_r      <= yh_nxt;
    iss_r     <= iss_nxt;
    rd_idx_r  <= iss_r;
    best_d_r  <= best_d_nxt;
    best_i_r  <= best_i_nxt;
    pick_r    <= pick_nxt;
    matched_r <= matched_nxt;
    status_r  <= status_nxt;
    if (out_load) begin
      out_status_r  <= status_r;
      out_pick_r    <= PICK_W'(pick_r);
      out_matched_r <= MATCH_W'(matched_r);
      out_stored_r  <= STORED_W'(pt_total_r);
      out_sel_len_r <= SEL_LEN_W'(sel_total_r);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_picked_index     = out_pick_r;
  assign out_matched_count    = out_matched_r;
  assign out_stored_points    = out_stored_r;
  assign out_selection_length = out_sel_len_r;

  // checks
  a_pt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pt_total_r <= PT_W'(MAX_POINTS))
    else $error("point count above table depth");

  a_sel_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sel_total_r <= ST_W'(SELECT_DEPTH))
    else $error("selection count above list depth");

  a_scan_addr: assert property (@(posedge clk) disable iff (!rst_n)
    pt_re |-> (PT_W'(iss_r) < pt_total_r))
    else $error("scan reads beyond stored points");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("controller idle right after taking a beat");

  a_eval_window: assert property (@(posedge clk) disable iff (!rst_n)
    ev.vld |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("evaluated point outside the scan window");

endmodule

@@ rtl/core/ppsel_ram.sv @@
// ----------------------------------------------------------------------------
// ppsel_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ppsel_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/ppsel_eval.sv @@
// ----------------------------------------------------------------------------
// ppsel_eval
// Three-stage point evaluation: absolute differences and rectangle test,
// squares, then the squared distance sum. One point beat per cycle.
// ----------------------------------------------------------------------------
module ppsel_eval #(
  parameter int unsigned IDX_W = 6
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     pt_vld,
  input  logic [IDX_W-1:0]                         pt_idx,
  input  logic signed [ppsel_pkg::COORD_W-1:0]     pt_x,
  input  logic signed [ppsel_pkg::COORD_W-1:0]     pt_y,
  input  logic signed [ppsel_pkg::COORD_W-1:0]     cur_x,
  input  logic signed [ppsel_pkg::COORD_W-1:0]     cur_y,
  input  logic signed [ppsel_pkg::COORD_W-1:0]     box_xl,
  input  logic signed [ppsel_pkg::COORD_W-1:0]     box_xh,
  input  logic signed [ppsel_pkg::COORD_W-1:0]     box_yl,
  input  logic signed [ppsel_pkg::COORD_W-1:0]     box_yh,
  output ppsel_pkg::ev_flags_t                     ev_flags,
  output logic [IDX_W-1:0]                         ev_idx,
  output logic [ppsel_pkg::DIST_W-1:0]             ev_dist
);
  import ppsel_pkg::*;

  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W-1:0]      ax, ay;
  logic                    inbox;

  // stage A: absolute differences and box test
  logic               va_r;
  logic [IDX_W-1:0]   idx_a_r;
  logic [COORD_W-1:0] ax_r, ay_r;
  logic               inbox_a_r;

  // stage M: squares
  logic               vm_r;
  logic [IDX_W-1:0]   idx_m_r;
  logic [SQ_W-1:0]    sqx_r, sqy_r;
  logic               inbox_m_r;

  // stage B: sum
  logic               vb_r;
  logic [IDX_W-1:0]   idx_b_r;
  logic [DIST_W-1:0]  dist_r;
  logic               inbox_b_r;

  // difference magnitudes fit in COORD_W bits unsigned
  always_comb begin
    dx    = {pt_x[COORD_W-1], pt_x} - {cur_x[COORD_W-1], cur_x};
    dy    = {pt_y[COORD_W-1], pt_y} - {cur_y[COORD_W-1], cur_y};
    ax    = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ay    = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    inbox = (pt_x >= box_xl) && (pt_x <= box_xh) &&
            (pt_y >= box_yl) && (pt_y <= box_yh);
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vm_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= pt_vld;
      vm_r <= va_r;
      vb_r <= vm_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    idx_a_r   <= pt_idx;
    ax_r      <= ax;
    ay_r      <= ay;
    inbox_a_r <= inbox;

    idx_m_r   <= idx_a_r;
    sqx_r     <= ax_r * ax_r;
    sqy_r     <= ay_r * ay_r;
    inbox_m_r <= inbox_a_r;

    idx_b_r   <= idx_m_r;
    dist_r    <= DIST_W'(sqx_r) + DIST_W'(sqy_r);
    inbox_b_r <= inbox_m_r;
  end

  assign ev_flags.busy  = va_r | vm_r;
  assign ev_flags.vld   = vb_r;
  assign ev_flags.inbox = inbox_b_r;
  assign ev_idx         = idx_b_r;
  assign ev_dist        = dist_r;

endmodule
